### design/frc_pkg.sv
// Shared types, constants and helpers for the fraction radix conversion unit.
// Used by frc_lane, frc_merge and fraction_radix_conversion_unit; no dependencies.
`default_nettype none

package frc_pkg;

  // Digits carried by one request on the input ports.
  localparam int PORT_DIGITS    = 8;
  // Digits of a request that take part in the conversion (1 to PORT_DIGITS).
  localparam int IN_DIGITS      = 8;
  localparam int MAX_BASE       = 16;
  localparam int MAX_OUT_DIGITS = 40;
  // The error band always closes within this many output digits.
  localparam int MAX_STEPS      = 33;
  localparam int STEP_CAP       = (MAX_OUT_DIGITS < MAX_STEPS) ? MAX_OUT_DIGITS : MAX_STEPS;

  localparam int DIG_W     = 4;
  localparam int BASE_W    = 5;
  localparam int POS_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = CFG_IDX_W'(1);
  localparam logic [BASE_W-1:0]    IN_BASE_RST  = BASE_W'(2);
  localparam logic [BASE_W-1:0]    OUT_BASE_RST = BASE_W'(10);

  // Datapath widths. D = in_base^IN_DIGITS, and all values count units of 1/(2D).
  localparam int LOG_B  = $clog2(MAX_BASE);
  localparam int NUM_W  = IN_DIGITS * LOG_B;
  localparam int FULL_W = NUM_W + 1;
  localparam int TWO_W  = FULL_W + 1;
  localparam int REM_W  = FULL_W;
  localparam int T_W    = REM_W + LOG_B;
  localparam int BND_W  = TWO_W + LOG_B;
  localparam int LANES  = MAX_BASE - 1;
  localparam int LD_W   = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_EVAL
  } state_t;

  // What one lane reports: whether the product reaches its multiple, and the difference.
  typedef struct packed {
    logic           ge;
    logic [T_W-1:0] diff;
  } lane_res_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_W'(2)) r = BASE_W'(2);
    else if (b > BASE_W'(MAX_BASE)) r = BASE_W'(MAX_BASE);
    return r;
  endfunction

endpackage

`default_nettype wire

### design/frc_lane.sv
// One quotient lane: holds k times the scaled unit 2D and tests the product against it.
// Depends on frc_pkg.
`default_nettype none

module frc_lane (
  input  logic                    clk,
  input  logic                    load,
  input  logic [frc_pkg::LOG_B-1:0] lane_k,
  input  logic [frc_pkg::TWO_W-1:0] two_full,
  input  logic [frc_pkg::T_W-1:0]   t,
  output frc_pkg::lane_res_t      res
);
  import frc_pkg::*;

  logic [T_W-1:0] mult_r;
  logic [T_W:0]   diff;

  always_ff @(posedge clk) begin
    if (load) begin
      mult_r <= T_W'(two_full) * T_W'(lane_k);
    end
  end

  // The borrow out of the subtraction says the product is below this multiple.
  assign diff     = {1'b0, t} - {1'b0, mult_r};
  assign res.ge   = ~diff[T_W];
  assign res.diff = diff[T_W-1:0];

endmodule

`default_nettype wire

### design/frc_merge.sv
// Merges the lane results into one output digit and the new remainder.
// Depends on frc_pkg.
`default_nettype none

module frc_merge (
  input  frc_pkg::lane_res_t      res [frc_pkg::LANES],
  input  logic [frc_pkg::T_W-1:0]   t,
  output logic [frc_pkg::DIG_W-1:0] u,
  output logic [frc_pkg::REM_W-1:0] rem
);
  import frc_pkg::*;

  // Lane hits are monotonic in k, so the highest hit gives the quotient.
  always_comb begin
    u   = '0;
    rem = REM_W'(t);
    for (int k = 0; k < LANES; k++) begin
      if (res[k].ge) begin
        u   = DIG_W'(k + 1);
        rem = REM_W'(res[k].diff);
      end
    end
  end

endmodule

`default_nettype wire

### design/fraction_radix_conversion_unit.sv
// Top level of the fraction radix conversion unit: control, datapath registers, lanes.
// Depends on frc_pkg, frc_lane and frc_merge.
//
// Usage. A request is accepted at a rising edge with start high and busy low; it
// carries eight fraction digits in the input base, most significant first. The
// block emits the shortest digit string in the output base that identifies the
// fraction, one digit per cycle of out_strobe, with out_position counting from
// one and out_last marking the final, rounded digit.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// in_base (index 0) and out_base (index 1); cfg_ready is always high, and the
// registers are meant to be written only while busy is low.
// Sequence. The digits are folded in one per cycle in ST_LOAD, then ST_PREP
// prepares the lane multiples. ST_MUL multiplies the remainder by out_base for
// the first digit; ST_DIV then forms each digit by the parallel lane compare,
// and ST_EVAL registers it for the strobe and, if more digits follow, multiplies
// the new remainder by out_base for the next one. A new request can be accepted
// once busy is low. The last strobe shows in the first idle cycle.
// Reset sets in_base to 2, out_base to 10 and returns the block to idle with no
// strobe. The receiver cannot stall; every strobed digit is taken at once.
`default_nettype none

module fraction_radix_conversion_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_1,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_2,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_3,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_4,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_5,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_6,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_7,
  input  logic [frc_pkg::DIG_W-1:0]     in_digit_8,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frc_pkg::BASE_W-1:0]    cfg_data,
  output logic                         out_strobe,
  output logic [frc_pkg::DIG_W-1:0]     out_digit,
  output logic [frc_pkg::POS_W-1:0]     out_position,
  output logic                         out_last
);
  import frc_pkg::*;

  state_t              state_r, state_nxt;
  logic [BASE_W-1:0]   in_base_r, out_base_r;
  logic [BASE_W-1:0]   ib, ob;
  logic [DIG_W-1:0]    in_all [PORT_DIGITS];
  logic [DIG_W-1:0]    dig_r  [IN_DIGITS];
  logic [DIG_W-1:0]    d_sat;
  logic [LD_W-1:0]     ld_cnt_r;
  logic [NUM_W-1:0]    num_r;
  logic [FULL_W-1:0]   full_r;
  logic [TWO_W-1:0]    two_full_r;
  logic [REM_W-1:0]    rem_r;
  logic [BND_W-1:0]    bnd_r;
  logic [T_W-1:0]      t_r;
  logic [DIG_W-1:0]    u_r;
  logic [POS_W-1:0]    cnt_r;
  logic                accept, load_done, go, round_up;
  logic                out_strobe_r, out_last_r;
  logic [DIG_W-1:0]    out_digit_r;
  logic [POS_W-1:0]    out_position_r;
  lane_res_t           lane_res [LANES];
  logic [DIG_W-1:0]    m_u;
  logic [REM_W-1:0]    m_rem;

  assign in_all[0] = in_digit_1;
  assign in_all[1] = in_digit_2;
  assign in_all[2] = in_digit_3;
  assign in_all[3] = in_digit_4;
  assign in_all[4] = in_digit_5;
  assign in_all[5] = in_digit_6;
  assign in_all[6] = in_digit_7;
  assign in_all[7] = in_digit_8;

  assign ib        = clamp_base(in_base_r);
  assign ob        = clamp_base(out_base_r);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign load_done = (ld_cnt_r == LD_W'(IN_DIGITS - 1));

  // A digit that is not below the input base saturates to the largest digit.
  assign d_sat = ({1'b0, dig_r[0]} >= ib) ? DIG_W'(ib - BASE_W'(1)) : dig_r[0];

  // Keep going while the remainder stays inside the band [M, 2D - M] and under STEP_CAP digits are formed.
  assign go = (BND_W'(two_full_r) >= bnd_r) &&
              (BND_W'(rem_r) >= bnd_r) &&
              ((BND_W + 1)'(rem_r) + (BND_W + 1)'(bnd_r) <= (BND_W + 1)'(two_full_r)) &&
              (cnt_r < POS_W'(STEP_CAP));
  assign round_up = (rem_r > full_r);

  genvar g;
  for (g = 0; g < LANES; g++) begin : g_lane
    frc_lane u_lane (
      .clk      (clk),
      .load     (state_r == ST_PREP),
      .lane_k   (LOG_B'(g + 1)),
      .two_full ({full_r, 1'b0}),
      .t        (t_r),
      .res      (lane_res[g])
    );
  end

  frc_merge u_merge (
    .res (lane_res),
    .t   (t_r),
    .u   (m_u),
    .rem (m_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_LOAD;
      ST_LOAD: if (load_done) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = go ? ST_DIV : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_base_r    <= IN_BASE_RST;
      out_base_r   <= OUT_BASE_RST;
      out_strobe_r <= 1'b0;
      ld_cnt_r     <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_EVAL);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IN_BASE:  in_base_r  <= cfg_data;
          REG_OUT_BASE: out_base_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) ld_cnt_r <= '0;
      else if (state_r == ST_LOAD) ld_cnt_r <= ld_cnt_r + LD_W'(1);
      if (state_r == ST_PREP) cnt_r <= '0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < IN_DIGITS; i++) dig_r[i] <= in_all[i];
          num_r  <= '0;
          full_r <= FULL_W'(1);
        end
      end
      ST_LOAD: begin
        num_r  <= NUM_W'(NUM_W'(num_r) * NUM_W'(ib) + NUM_W'(d_sat));
        full_r <= FULL_W'(full_r) * FULL_W'(ib);
        for (int i = 0; i < IN_DIGITS - 1; i++) dig_r[i] <= dig_r[i + 1];
      end
      ST_PREP: begin
        two_full_r <= {full_r, 1'b0};
        rem_r      <= {num_r, 1'b0};
        bnd_r      <= BND_W'(1);
      end
      ST_MUL: begin
        t_r   <= T_W'(rem_r) * T_W'(ob);
        bnd_r <= bnd_r * BND_W'(ob);
      end
      ST_DIV: begin
        rem_r <= m_rem;
        u_r   <= m_u;
      end
      ST_EVAL: begin
        // Only the final digit is rounded.
        out_digit_r    <= (!go && round_up) ? u_r + DIG_W'(1) : u_r;
        out_position_r <= cnt_r;
        out_last_r     <= !go;
        if (go) begin
          t_r   <= T_W'(rem_r) * T_W'(ob);
          bnd_r <= bnd_r * BND_W'(ob);
        end
      end
      default: ;
    endcase
  end

  assign out_strobe   = out_strobe_r;
  assign out_digit    = out_digit_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;

  // Digit strobes never come back to back.
  assert property (@(posedge clk) disable iff (!rst_n) out_strobe_r |=> !out_strobe_r)
    else $error("digit strobes on consecutive cycles");

  // An emitted digit, rounding included, stays below the output base.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_strobe_r |-> ({1'b0, out_digit_r} < ob))
    else $error("digit not below the output base");

  // A digit that is not the last one leaves the block still converting.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_strobe_r && !out_last_r) |-> busy)
    else $error("conversion ended without a last digit");

  // Positions run from one upward.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_strobe_r |-> (out_position_r != '0))
    else $error("digit position zero");

endmodule

`default_nettype wire
